// ===== sv/deq_pkg.sv =====
package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell; set only for a successful operation.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_ctrl_t;

endpackage

// ===== sv/deq_cell.sv =====
module deq_cell #(
  parameter int INDEX  = 0,
  parameter int CountW = 5
) (
  input  logic                              clk,
  input  deq_pkg::cell_ctrl_t               ctrl,
  input  logic [CountW-1:0]                 count,
  input  logic signed [deq_pkg::WORD_W-1:0] value_in,
  input  logic signed [deq_pkg::WORD_W-1:0] f_prev,
  input  logic signed [deq_pkg::WORD_W-1:0] f_next,
  input  logic signed [deq_pkg::WORD_W-1:0] r_prev,
  input  logic signed [deq_pkg::WORD_W-1:0] r_next,
  output logic signed [deq_pkg::WORD_W-1:0] f,
  output logic signed [deq_pkg::WORD_W-1:0] r
);

  // The f chain holds the queue in front-to-rear order, the r chain in
  // rear-to-front order, so both ends always sit in cell zero.
  logic at_count;
  logic signed [deq_pkg::WORD_W-1:0] f_next_val;
  logic signed [deq_pkg::WORD_W-1:0] r_next_val;

  assign at_count = (count == CountW'(INDEX));

  always_comb begin
    f_next_val = f;
    r_next_val = r;
    if (ctrl.push_front) begin
      f_next_val = f_prev;
      if (at_count) begin
        r_next_val = value_in;
      end
    end else if (ctrl.push_rear) begin
      r_next_val = r_prev;
      if (at_count) begin
        f_next_val = value_in;
      end
    end else if (ctrl.pop_front) begin
      f_next_val = f_next;
    end else if (ctrl.pop_rear) begin
      r_next_val = r_next;
    end
  end

  always_ff @(posedge clk) begin
    f <= f_next_val;
    r <= r_next_val;
  end

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// Bounded double-ended queue of signed 32-bit words, DEPTH entries deep.
// Input channel: in_valid/in_stall with operation and value_in. Operations are
// push front, push rear, pop front and pop rear. Output channel:
// out_valid/out_stall with value_out, status and fill_count, one result per
// input transaction, in order.
// Storage is a row of identical cells holding the queue twice, once in front
// order and once in rear order, so both ends are always in the first cell. Every
// successful operation shifts one order by one cell; a push also writes the cell at the count in the other.
// The result is registered and appears in the cycle after its transaction is taken;
// one transaction is taken per cycle while the receiver does not stall a pending result.
// A push to a full queue reports overflow, a pop from an empty queue reports
// underflow; neither changes the contents. value_out is zero unless a pop
// succeeds.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// cell contents are not cleared and need no clearing pass.
// While the receiver stalls a pending result, in_stall is raised and no new
// transaction is taken; the result holds until it is taken.
module double_ended_queue_unit #(
  parameter int  DEPTH  = deq_pkg::DEPTH_DEFAULT,
  localparam int CountW = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic signed [deq_pkg::WORD_W-1:0] value_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [deq_pkg::WORD_W-1:0] value_out,
  output logic [1:0]                        status,
  output logic [CountW-1:0]                 fill_count
);

  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic              take;
  logic              is_push;
  logic              full;
  logic              empty;
  logic              op_ok;
  deq_pkg::op_t      op;
  deq_pkg::cell_ctrl_t ctrl;
  deq_pkg::status_t  status_next;
  logic signed [deq_pkg::WORD_W-1:0] result_next;
  logic signed [deq_pkg::WORD_W-1:0] f_q [DEPTH];
  logic signed [deq_pkg::WORD_W-1:0] r_q [DEPTH];

  assign op       = deq_pkg::op_t'(operation);
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;
  assign is_push  = (op == deq_pkg::OP_PUSH_FRONT) || (op == deq_pkg::OP_PUSH_REAR);
  assign full     = (count == CountW'(DEPTH));
  assign empty    = (count == '0);
  assign op_ok    = is_push ? !full : !empty;

  always_comb begin
    ctrl = '0;
    if (take && op_ok) begin
      unique case (op)
        deq_pkg::OP_PUSH_FRONT: ctrl.push_front = 1'b1;
        deq_pkg::OP_PUSH_REAR:  ctrl.push_rear  = 1'b1;
        deq_pkg::OP_POP_FRONT:  ctrl.pop_front  = 1'b1;
        deq_pkg::OP_POP_REAR:   ctrl.pop_rear   = 1'b1;
        default:                ctrl            = '0;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (ctrl.push_front || ctrl.push_rear) begin
      count_next = count + CountW'(1);
    end else if (ctrl.pop_front || ctrl.pop_rear) begin
      count_next = count - CountW'(1);
    end
  end

  always_comb begin
    result_next = '0;
    status_next = deq_pkg::ST_OK;
    if (!op_ok) begin
      status_next = is_push ? deq_pkg::ST_OVERFLOW : deq_pkg::ST_UNDERFLOW;
    end else if (op == deq_pkg::OP_POP_FRONT) begin
      result_next = f_q[0];
    end else if (op == deq_pkg::OP_POP_REAR) begin
      result_next = r_q[0];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::WORD_W-1:0] f_prev;
    logic signed [deq_pkg::WORD_W-1:0] f_next;
    logic signed [deq_pkg::WORD_W-1:0] r_prev;
    logic signed [deq_pkg::WORD_W-1:0] r_next;

    if (i == 0) begin : g_first
      assign f_prev = value_in;
      assign r_prev = value_in;
    end else begin : g_mid
      assign f_prev = f_q[i-1];
      assign r_prev = r_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign f_next = f_q[i];
      assign r_next = r_q[i];
    end else begin : g_inner
      assign f_next = f_q[i+1];
      assign r_next = r_q[i+1];
    end

    deq_cell #(
      .INDEX  (i),
      .CountW (CountW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .value_in (value_in),
      .f_prev   (f_prev),
      .f_next   (f_next),
      .r_prev   (r_prev),
      .r_next   (r_next),
      .f        (f_q[i]),
      .r        (r_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value_out  <= result_next;
      status     <= status_next;
      fill_count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (take && !is_push && empty) |=>
      (out_valid && status == deq_pkg::ST_UNDERFLOW && value_out == '0))
    else $error("pop from an empty queue did not report underflow");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (take && is_push && full) |=>
      (status == deq_pkg::ST_OVERFLOW && fill_count == CountW'(DEPTH) && $stable(count)))
    else $error("push to a full queue did not report overflow");

  a_single_entry: assert property (@(posedge clk) disable iff (rst)
    (count == CountW'(1)) |-> (f_q[0] == r_q[0]))
    else $error("front and rear chains disagree on a single entry");
`endif

endmodule

// ===== tb/sv/tb_double_ended_queue_unit.sv =====
module tb_double_ended_queue_unit;

  localparam int DEPTH = 16;
  localparam int WORD_W = deq_pkg::WORD_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CLK_PERIOD = 12;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    deq_pkg::status_t         stat;
    logic [CNT_W-1:0]         fill;
  } deq_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = 2'd0;
  logic signed [WORD_W-1:0] value_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WORD_W-1:0] value_out;
  logic [1:0] status;
  logic [CNT_W-1:0] fill_count;

  // Shadow copy of the queue contents.
  logic signed [WORD_W-1:0] ring_words [DEPTH];
  int head_pos = 0;
  int held = 0;

  deq_outcome_t outcome_fifo [$];
  int mismatch_count = 0;
  bit idle_on = 1'b0;
  bit hold_request = 1'b0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .status    (status),
    .fill_count(fill_count)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 200000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Applies one operation to the shadow queue and records the outcome it must produce.
  function automatic void model_deque_op(input deq_pkg::op_t op,
                                         input logic signed [WORD_W-1:0] word);
    deq_outcome_t res;
    res.word = '0;
    res.stat = deq_pkg::ST_OK;
    case (op) inside
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
        if (held == DEPTH) begin
          res.stat = deq_pkg::ST_OVERFLOW;
        end else begin
          if (op == deq_pkg::OP_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            ring_words[head_pos] = word;
          end else begin
            ring_words[(head_pos + held) % DEPTH] = word;
          end
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          res.stat = deq_pkg::ST_UNDERFLOW;
        end else begin
          if (op == deq_pkg::OP_POP_FRONT) begin
            res.word = ring_words[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            res.word = ring_words[(head_pos + held - 1) % DEPTH];
          end
          held--;
        end
      end
    endcase
    res.fill = CNT_W'(held);
    outcome_fifo.push_back(res);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      4: return WORD_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Offers one transaction and returns at the edge where it is taken. Valid stays
  // high afterwards so back-to-back transactions need no extra edge.
  task automatic send_op(input deq_pkg::op_t op, input logic signed [WORD_W-1:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value_in  <= word;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    model_deque_op(op, word);
  endtask

  // Runs of pushes or pops with a random bias, so the queue swings between
  // empty and full many times.
  task automatic run_mixed_ops(input int n_items);
    int sent;
    int run_len;
    int push_pct;
    deq_pkg::op_t op;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(4, 24);
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        if ($urandom_range(1, 100) <= push_pct) begin
          op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
        end
        send_op(op, pick_word());
        sent++;
      end
    end
  endtask

  task automatic test_empty_pops();
    send_op(deq_pkg::OP_POP_FRONT, 32'sh1234_5678);
    send_op(deq_pkg::OP_POP_REAR, -32'sd1);
  endtask

  task automatic test_extreme_words();
    send_op(deq_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_op(deq_pkg::OP_PUSH_REAR, 32'sh8000_0000);
    send_op(deq_pkg::OP_POP_REAR, '0);
    send_op(deq_pkg::OP_POP_FRONT, '0);
  endtask

  // A single entry must leave the queue empty when taken from the rear, whichever end it was pushed at.
  task automatic test_last_element();
    send_op(deq_pkg::OP_PUSH_REAR, -32'sd1);
    send_op(deq_pkg::OP_POP_REAR, '0);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'sh5555_AAAA);
    send_op(deq_pkg::OP_POP_REAR, '0);
  endtask

  task automatic test_fill_and_overflow();
    for (int k = 0; k < DEPTH; k++) begin
      send_op(k[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR, $urandom);
    end
    send_op(deq_pkg::OP_PUSH_FRONT, 32'sh0F0F_0F0F);
    send_op(deq_pkg::OP_PUSH_REAR, 32'shF0F0_F0F0);
  endtask

  task automatic test_random_mix_idling();
    idle_on = 1'b1;
    run_mixed_ops(320);
  endtask

  // The receiver holds off for a long stretch while transactions keep coming,
  // so the block has to stall its input.
  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_request = 1'b1;
    run_mixed_ops(50);
  endtask

  task automatic test_random_mix_full_rate();
    idle_on = 1'b0;
    run_mixed_ops(300);
  endtask

  initial begin : receiver
    int burst_left;
    int hold_count;
    burst_left = 0;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        hold_count++;
        if (hold_count == LONG_HOLD) begin
          hold_request = 1'b0;
          hold_count = 0;
        end
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    deq_outcome_t exp_res;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (outcome_fifo.size() == 0) begin
        $display("%0t: unexpected transaction value_out %0d status %0d fill_count %0d",
                 $time, value_out, status, fill_count);
        mismatch_count++;
      end else begin
        exp_res = outcome_fifo.pop_front();
        if (value_out !== exp_res.word) begin
          $display("%0t: value_out expected %0d actual %0d", $time, exp_res.word, value_out);
          mismatch_count++;
        end
        if (status !== exp_res.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.stat, status);
          mismatch_count++;
        end
        if (fill_count !== exp_res.fill) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, exp_res.fill, fill_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pops();
    test_extreme_words();
    test_last_element();
    test_fill_and_overflow();
    test_random_mix_idling();
    test_output_hold();
    test_random_mix_full_rate();

    in_valid <= 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_unit.f =====
sv/deq_pkg.sv
sv/deq_cell.sv
sv/double_ended_queue_unit.sv
tb/sv/tb_double_ended_queue_unit.sv
